>>> src/addm_pkg.sv
// Package for the armed differential drive mixer.
// Widths, reset constants and the stage register type; no dependencies.
`timescale 1ns / 1ps

package addm_pkg;

  localparam int unsigned StickW  = 8;
  localparam int unsigned DzW     = 7;
  localparam int unsigned DutyW   = 8;
  localparam int unsigned SpeedW  = 7;

  localparam logic [DzW-1:0]    DeadzoneReset = 7'd10;
  localparam logic [SpeedW-1:0] SpeedLimit    = 7'd127;

  // Stage 1 contents: sticks plus the control state after this beat.
  typedef struct packed {
    logic                     drive_en;
    logic                     armed;
    logic                     killed;
    logic signed [StickW-1:0] fwd;
    logic signed [StickW-1:0] turn;
  } stage_t;

endpackage

>>> src/armed_differential_drive_mixer.sv
// Armed differential drive mixer: arm/kill control and arcade drive mixing.
// Two-stage pipeline (input register, result register). Depends on addm_pkg.
//
//  channel | signals                                              | dir
//  --------+------------------------------------------------------+-----
//  in      | in_valid_i/in_ready_o, link_up_i, start_button_i,    | in
//          | select_button_i, stick_forward_i, stick_turn_i       |
//  out     | out_valid_o/out_ready_i, left/right fwd/rev duty,    | out
//          | armed_flag_o, kill_flag_o                            |
//  cfg     | cfg_valid_i/cfg_ready_o, cfg_deadzone_i              | in
//
// One beat per cycle sustained unless the output stalls.
// Arm/kill state updates as the input beat is taken; deadzone, mix, clamp and
// duty scaling sit between the stage register and the result register.
// Reset clears the control state and pipeline valids; deadzone resets to 10.
// An output stall backs up through both stages before in_ready_o drops.
`timescale 1ns / 1ps

module armed_differential_drive_mixer (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  link_up_i,
  input  logic                                  start_button_i,
  input  logic                                  select_button_i,
  input  logic signed [addm_pkg::StickW-1:0]    stick_forward_i,
  input  logic signed [addm_pkg::StickW-1:0]    stick_turn_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic        [addm_pkg::DutyW-1:0]     left_fwd_duty_o,
  output logic        [addm_pkg::DutyW-1:0]     left_rev_duty_o,
  output logic        [addm_pkg::DutyW-1:0]     right_fwd_duty_o,
  output logic        [addm_pkg::DutyW-1:0]     right_rev_duty_o,
  output logic                                  armed_flag_o,
  output logic                                  kill_flag_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic        [addm_pkg::DzW-1:0]       cfg_deadzone_i
);
  import addm_pkg::*;

  logic [DzW-1:0] deadzone_q;

  logic armed_q, armed_d, killed_q, killed_d;
  logic last_start_q, last_start_d, last_select_q, last_select_d;

  logic   s1_valid_q;
  stage_t s1_q, s1_d;

  logic             out_valid_q;
  logic [DutyW-1:0] lf_q, lr_q, rf_q, rr_q, lf_d, lr_d, rf_d, rr_d;
  logic             armed_out_q, killed_out_q;

  logic in_take, out_free, s1_move;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_move    = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign in_take    = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // Deadzone: magnitude below threshold reads as zero; -128 has magnitude 128.
  function automatic logic signed [StickW-1:0] dz_apply(
    input logic signed [StickW-1:0] v,
    input logic        [DzW-1:0]    dz
  );
    logic [StickW-1:0] mag;
    mag = v[StickW-1] ? StickW'(-v) : StickW'(v);
    return (mag < {1'b0, dz}) ? '0 : v;
  endfunction

  // Clamp to +-127, then duty = |s|*255/127 = 2|s| + (|s| == 127).
  function automatic logic [2*DutyW-1:0] side_duty(input logic signed [StickW:0] s);
    logic [SpeedW-1:0] mag;
    logic [DutyW-1:0]  duty;
    if (s > $signed({2'b00, SpeedLimit})) begin
      mag = SpeedLimit;
    end else if (s < -$signed({2'b00, SpeedLimit})) begin
      mag = SpeedLimit;
    end else if (s[StickW]) begin
      mag = SpeedW'(-s);
    end else begin
      mag = SpeedW'(s);
    end
    duty = {mag, 1'b0} + DutyW'(mag == SpeedLimit);
    if (s[StickW]) begin
      return {DutyW'(0), duty};
    end else begin
      return {duty, DutyW'(0)};
    end
  endfunction

  // Control state: select edge kills and disarms, start edge clears kill
  // or toggles armed. No update while the link is down.
  always_comb begin
    armed_d       = armed_q;
    killed_d      = killed_q;
    last_start_d  = last_start_q;
    last_select_d = last_select_q;
    if (link_up_i) begin
      if (select_button_i && !last_select_q) begin
        killed_d = 1'b1;
        armed_d  = 1'b0;
      end
      if (start_button_i && !last_start_q) begin
        if (killed_d) begin
          killed_d = 1'b0;
        end else begin
          armed_d = !armed_d;
        end
      end
      last_start_d  = start_button_i;
      last_select_d = select_button_i;
    end
    s1_d.drive_en = link_up_i && armed_d && !killed_d;
    s1_d.armed    = armed_d;
    s1_d.killed   = killed_d;
    s1_d.fwd      = stick_forward_i;
    s1_d.turn     = stick_turn_i;
  end

  always_comb begin
    logic signed [StickW-1:0] f, t;
    logic signed [StickW:0]   left_s, right_s;
    logic [2*DutyW-1:0]       ld, rd;
    f       = dz_apply(s1_q.fwd, deadzone_q);
    t       = dz_apply(s1_q.turn, deadzone_q);
    left_s  = {f[StickW-1], f} + {t[StickW-1], t};
    right_s = {f[StickW-1], f} - {t[StickW-1], t};
    ld      = side_duty(left_s);
    rd      = side_duty(right_s);
    if (s1_q.drive_en) begin
      {lf_d, lr_d} = ld;
      {rf_d, rr_d} = rd;
    end else begin
      lf_d = '0;
      lr_d = '0;
      rf_d = '0;
      rr_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadzone_q    <= DeadzoneReset;
      armed_q       <= 1'b0;
      killed_q      <= 1'b0;
      last_start_q  <= 1'b0;
      last_select_q <= 1'b0;
      s1_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        deadzone_q <= cfg_deadzone_i;
      end
      if (in_take) begin
        armed_q       <= armed_d;
        killed_q      <= killed_d;
        last_start_q  <= last_start_d;
        last_select_q <= last_select_d;
      end
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_q <= s1_d;
    end
    if (s1_move) begin
      lf_q         <= lf_d;
      lr_q         <= lr_d;
      rf_q         <= rf_d;
      rr_q         <= rr_d;
      armed_out_q  <= s1_q.armed;
      killed_out_q <= s1_q.killed;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign left_fwd_duty_o  = lf_q;
  assign left_rev_duty_o  = lr_q;
  assign right_fwd_duty_o = rf_q;
  assign right_rev_duty_o = rr_q;
  assign armed_flag_o     = armed_out_q;
  assign kill_flag_o      = killed_out_q;

  // Checks
  a_state_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(armed_q && killed_q))
    else $error("armed and killed both set");

  a_side_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((lf_q == '0) || (lr_q == '0)) && ((rf_q == '0) || (rr_q == '0)))
    else $error("forward and reverse duty both active on one side");

  a_safe_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (!armed_out_q || killed_out_q)) |->
      (lf_q == '0) && (lr_q == '0) && (rf_q == '0) && (rr_q == '0))
    else $error("duty output while disarmed or killed");

  a_link_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_take && !link_up_i) |=> $stable(armed_q) && $stable(killed_q)
      && $stable(last_start_q) && $stable(last_select_q))
    else $error("control state changed with link down");

endmodule

>>> sim/testbench.sv
// Testbench for armed_differential_drive_mixer: arm/kill control and drive mixing.
// Checks every result beat against an in-bench predictor; depends on addm_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;
  import addm_pkg::*;

  localparam int QuietLimit = 5000;

  typedef struct packed {
    logic [DutyW-1:0] left_fwd;
    logic [DutyW-1:0] left_rev;
    logic [DutyW-1:0] right_fwd;
    logic [DutyW-1:0] right_rev;
    logic             armed;
    logic             killed;
  } drive_result_t;

  logic                     clk_i           = 1'b0;
  logic                     rst_ni          = 1'b0;
  logic                     in_valid_i      = 1'b0;
  logic                     in_ready_o;
  logic                     link_up_i       = 1'b0;
  logic                     start_button_i  = 1'b0;
  logic                     select_button_i = 1'b0;
  logic signed [StickW-1:0] stick_forward_i = '0;
  logic signed [StickW-1:0] stick_turn_i    = '0;
  logic                     out_valid_o;
  logic                     out_ready_i     = 1'b0;
  logic        [DutyW-1:0]  left_fwd_duty_o;
  logic        [DutyW-1:0]  left_rev_duty_o;
  logic        [DutyW-1:0]  right_fwd_duty_o;
  logic        [DutyW-1:0]  right_rev_duty_o;
  logic                     armed_flag_o;
  logic                     kill_flag_o;
  logic                     cfg_valid_i     = 1'b0;
  logic                     cfg_ready_o;
  logic        [DzW-1:0]    cfg_deadzone_i  = '0;

  // predictor state
  logic [DzW-1:0] dz_setting  = DeadzoneReset;
  logic           drv_armed   = 1'b0;
  logic           drv_killed  = 1'b0;
  logic           prev_start  = 1'b0;
  logic           prev_select = 1'b0;

  drive_result_t duty_expect_q[$];
  int            mismatch_count  = 0;
  int            quiet_cycles    = 0;
  int            sender_idle_pct = 0;
  int            ready_stall_pct = 0;

  armed_differential_drive_mixer uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .link_up_i        (link_up_i),
    .start_button_i   (start_button_i),
    .select_button_i  (select_button_i),
    .stick_forward_i  (stick_forward_i),
    .stick_turn_i     (stick_turn_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .left_fwd_duty_o  (left_fwd_duty_o),
    .left_rev_duty_o  (left_rev_duty_o),
    .right_fwd_duty_o (right_fwd_duty_o),
    .right_rev_duty_o (right_rev_duty_o),
    .armed_flag_o     (armed_flag_o),
    .kill_flag_o      (kill_flag_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_deadzone_i   (cfg_deadzone_i)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic int dz_filter(int v);
    int mag;
    mag = (v < 0) ? -v : v;
    return (mag < int'(dz_setting)) ? 0 : v;
  endfunction

  function automatic int limit_speed(int v);
    if (v > int'(SpeedLimit)) return int'(SpeedLimit);
    if (v < -int'(SpeedLimit)) return -int'(SpeedLimit);
    return v;
  endfunction

  // returns {fwd, rev} duty for one side
  function automatic logic [2*DutyW-1:0] speed_to_duty(int s);
    int mag;
    int duty;
    mag  = (s < 0) ? -s : s;
    duty = (mag * 255) / int'(SpeedLimit);
    if (s > 0) return {duty[DutyW-1:0], {DutyW{1'b0}}};
    if (s < 0) return {{DutyW{1'b0}}, duty[DutyW-1:0]};
    return '0;
  endfunction

  function automatic drive_result_t mix_sample(logic link, logic start, logic sel,
                                               logic signed [StickW-1:0] fwd,
                                               logic signed [StickW-1:0] turn);
    drive_result_t r;
    int f;
    int t;
    r = '0;
    if (link) begin
      // select acts before start when both rise together
      if (sel && !prev_select) begin
        drv_killed = 1'b1;
        drv_armed  = 1'b0;
      end
      if (start && !prev_start) begin
        if (drv_killed) drv_killed = 1'b0;
        else drv_armed = !drv_armed;
      end
      prev_start  = start;
      prev_select = sel;
      if (drv_armed && !drv_killed) begin
        f = dz_filter(int'(fwd));
        t = dz_filter(int'(turn));
        {r.left_fwd, r.left_rev}   = speed_to_duty(limit_speed(f + t));
        {r.right_fwd, r.right_rev} = speed_to_duty(limit_speed(f - t));
      end
    end
    r.armed  = drv_armed;
    r.killed = drv_killed;
    return r;
  endfunction

  task automatic report_mismatch(string what);
    mismatch_count++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  task automatic check_field(string name, logic [DutyW-1:0] got, logic [DutyW-1:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // returns at the posedge where the beat is taken
  task automatic send_sample(logic link, logic start, logic sel,
                             logic signed [StickW-1:0] fwd, logic signed [StickW-1:0] turn);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    link_up_i       <= link;
    start_button_i  <= start;
    select_button_i <= sel;
    stick_forward_i <= fwd;
    stick_turn_i    <= turn;
    do @(posedge clk_i); while (!in_ready_o);
    duty_expect_q.push_back(mix_sample(link, start, sel, fwd, turn));
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (duty_expect_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_deadzone(logic [DzW-1:0] value);
    settle();
    cfg_valid_i    <= 1'b1;
    cfg_deadzone_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    dz_setting  = value;
    cfg_valid_i <= 1'b0;
  endtask

  // release buttons, then pulse start until armed and not killed
  task automatic arm_drive();
    send_sample(1'b1, 1'b0, 1'b0, 8'sd0, 8'sd0);
    if (drv_killed) begin
      send_sample(1'b1, 1'b1, 1'b0, 8'sd0, 8'sd0);
      send_sample(1'b1, 1'b0, 1'b0, 8'sd0, 8'sd0);
    end
    if (!drv_armed) begin
      send_sample(1'b1, 1'b1, 1'b0, 8'sd0, 8'sd0);
      send_sample(1'b1, 1'b0, 1'b0, 8'sd0, 8'sd0);
    end
  endtask

  function automatic logic signed [StickW-1:0] pick_stick();
    int v;
    case ($urandom_range(9))
      0: return -8'sd128;
      1: return 8'sd127;
      2: return -8'sd127;
      3, 4: begin
        // straddle the deadzone threshold
        v = int'(dz_setting) - 1 + $urandom_range(2);
        if ($urandom_range(1)) v = -v;
        return v[StickW-1:0];
      end
      default: return StickW'($urandom_range(255));
    endcase
  endfunction

  task automatic test_directed();
    send_sample(1'b1, 1'b0, 1'b0, 8'sd100, 8'sd50);    // disarmed, sticks ignored
    send_sample(1'b0, 1'b1, 1'b0, 8'sd127, 8'sd0);     // link down hides start
    send_sample(1'b1, 1'b1, 1'b0, 8'sd127, 8'sd0);     // start rise arms
    send_sample(1'b1, 1'b1, 1'b0, -8'sd128, -8'sd128);
    send_sample(1'b1, 1'b0, 1'b0, 8'sd0, 8'sd127);
    send_sample(1'b1, 1'b0, 1'b0, 8'sd9, -8'sd9);      // inside deadzone
    send_sample(1'b1, 1'b0, 1'b0, 8'sd10, -8'sd10);    // right at deadzone
    send_sample(1'b1, 1'b0, 1'b0, -8'sd128, 8'sd127);
    send_sample(1'b0, 1'b0, 1'b1, 8'sd50, 8'sd50);     // link down keeps state
    send_sample(1'b1, 1'b0, 1'b1, 8'sd50, 8'sd50);     // select edge seen now
    send_sample(1'b1, 1'b0, 1'b1, 8'sd50, 8'sd50);
    send_sample(1'b1, 1'b1, 1'b1, 8'sd50, 8'sd50);     // start clears kill
    send_sample(1'b1, 1'b0, 1'b0, 8'sd50, 8'sd50);
    send_sample(1'b1, 1'b1, 1'b1, 8'sd50, 8'sd50);     // both rise together
    send_sample(1'b1, 1'b0, 1'b0, 8'sd50, 8'sd50);
    send_sample(1'b1, 1'b1, 1'b0, -8'sd60, 8'sd30);
    send_sample(1'b1, 1'b0, 1'b0, 8'sd127, 8'sd127);
    send_sample(1'b1, 1'b0, 1'b0, 8'sd0, 8'sd0);       // zero speed both sides
    send_sample(1'b1, 1'b1, 1'b0, 8'sd40, 8'sd40);     // start toggles off
    send_sample(1'b1, 1'b0, 1'b0, 8'sd40, 8'sd40);
  endtask

  task automatic test_deadzone_extremes();
    set_deadzone(7'd0);
    arm_drive();
    send_sample(1'b1, 1'b0, 1'b0, 8'sd1, -8'sd1);
    send_sample(1'b1, 1'b0, 1'b0, -8'sd1, 8'sd0);
    set_deadzone(7'd127);
    arm_drive();
    send_sample(1'b1, 1'b0, 1'b0, 8'sd126, -8'sd126);
    send_sample(1'b1, 1'b0, 1'b0, 8'sd127, -8'sd128);
    send_sample(1'b1, 1'b0, 1'b0, -8'sd127, 8'sd126);
  endtask

  task automatic test_random(int count, int idle_pct, int stall_pct);
    logic link;
    logic start_lvl;
    logic sel_lvl;
    start_lvl       = 1'b0;
    sel_lvl         = 1'b0;
    sender_idle_pct = idle_pct;
    ready_stall_pct = stall_pct;
    repeat (count) begin
      link = ($urandom_range(99) >= 8);
      if ($urandom_range(99) < 10) begin
        // noise: arbitrary button levels
        start_lvl = 1'($urandom_range(1));
        sel_lvl   = 1'($urandom_range(1));
      end else begin
        if ($urandom_range(99) < 12) start_lvl = !start_lvl;
        if ($urandom_range(99) < 4) sel_lvl = !sel_lvl;
      end
      send_sample(link, start_lvl, sel_lvl, pick_stick(), pick_stick());
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_deadzone_extremes();
    set_deadzone(7'($urandom_range(1, 30)));
    test_random(300, 0, 0);
    set_deadzone(7'd0);
    test_random(300, 74, 0);
    set_deadzone(7'($urandom_range(127)));
    test_random(300, 0, 74);
    set_deadzone(DeadzoneReset);
    test_random(300, 13, 13);
    settle();
    if (mismatch_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= ready_stall_pct);
  end

  // result beats are compared against pre-edge values
  always @(posedge clk_i) begin
    drive_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (duty_expect_q.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = duty_expect_q.pop_front();
        check_field("left_fwd_duty", left_fwd_duty_o, want.left_fwd);
        check_field("left_rev_duty", left_rev_duty_o, want.left_rev);
        check_field("right_fwd_duty", right_fwd_duty_o, want.right_fwd);
        check_field("right_rev_duty", right_rev_duty_o, want.right_rev);
        check_field("armed_flag", DutyW'(armed_flag_o), DutyW'(want.armed));
        check_field("kill_flag", DutyW'(kill_flag_o), DutyW'(want.killed));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("timeout with %0d results outstanding", duty_expect_q.size());
      $display("testbench failed");
      $finish;
    end
  end

endmodule
